>>> rtl/dq_pkg.sv
`timescale 1ns / 1ps

package dq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int OUT_COUNT_W = 5;

    typedef enum logic [1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_BACK  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_BACK   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
    } t_mem_req;

    typedef struct packed {
        logic               valid;
        logic               pop;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_result;

endpackage

>>> rtl/dq_ram.sv
`timescale 1ns / 1ps

module dq_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/dq_ctrl.sv
`timescale 1ns / 1ps

module dq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [1:0]       i_action,
    output dq_pkg::t_mem_req o_mem_req,
    output dq_pkg::t_result  o_result
);

    localparam logic [dq_pkg::ADDR_W-1:0] LastAddr = dq_pkg::ADDR_W'(dq_pkg::QUEUE_DEPTH - 1);
    localparam logic [dq_pkg::COUNT_W-1:0] FullCount = dq_pkg::COUNT_W'(dq_pkg::QUEUE_DEPTH);

    logic [dq_pkg::ADDR_W-1:0]  r_front, n_front;
    logic [dq_pkg::ADDR_W-1:0]  r_back, n_back;
    logic [dq_pkg::COUNT_W-1:0] r_count, n_count;
    logic                       r_valid, n_valid;
    logic                       r_pop, n_pop;
    dq_pkg::t_status            r_status, n_status;

    logic [dq_pkg::ADDR_W-1:0] front_prev, front_next, back_prev, back_next;
    dq_pkg::t_action           act;
    logic                      is_full, is_zero;

    always_comb begin
        front_prev = (r_front == '0) ? LastAddr : r_front - 1'b1;
        front_next = (r_front == LastAddr) ? '0 : r_front + 1'b1;
        back_prev  = (r_back == '0) ? LastAddr : r_back - 1'b1;
        back_next  = (r_back == LastAddr) ? '0 : r_back + 1'b1;
        is_full    = (r_count == FullCount);
        is_zero    = (r_count == '0);
        act        = dq_pkg::t_action'(i_action);

        n_front         = r_front;
        n_back          = r_back;
        n_count         = r_count;
        n_valid         = i_accept;
        n_pop           = 1'b0;
        n_status        = dq_pkg::ST_OK;
        o_mem_req.wr_en = 1'b0;
        o_mem_req.rd_en = 1'b0;
        o_mem_req.addr  = r_back;

        if (i_accept) begin
            case (act)
                dq_pkg::ACT_PUSH_FRONT: begin
                    if (is_full) begin
                        n_status = dq_pkg::ST_FULL;
                    end else begin
                        n_front         = front_prev;
                        n_count         = r_count + 1'b1;
                        o_mem_req.wr_en = 1'b1;
                        o_mem_req.addr  = front_prev;
                    end
                end
                dq_pkg::ACT_PUSH_BACK: begin
                    if (is_full) begin
                        n_status = dq_pkg::ST_FULL;
                    end else begin
                        n_back          = back_next;
                        n_count         = r_count + 1'b1;
                        o_mem_req.wr_en = 1'b1;
                        o_mem_req.addr  = r_back;
                    end
                end
                dq_pkg::ACT_POP_FRONT: begin
                    if (is_zero) begin
                        n_status = dq_pkg::ST_EMPTY;
                    end else begin
                        n_front         = front_next;
                        n_count         = r_count - 1'b1;
                        n_pop           = 1'b1;
                        o_mem_req.rd_en = 1'b1;
                        o_mem_req.addr  = r_front;
                    end
                end
                default: begin
                    if (is_zero) begin
                        n_status = dq_pkg::ST_EMPTY;
                    end else begin
                        n_back          = back_prev;
                        n_count         = r_count - 1'b1;
                        n_pop           = 1'b1;
                        o_mem_req.rd_en = 1'b1;
                        o_mem_req.addr  = back_prev;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '0;
            r_back   <= '0;
            r_count  <= '0;
            r_valid  <= 1'b0;
            r_pop    <= 1'b0;
            r_status <= dq_pkg::ST_OK;
        end else begin
            r_front  <= n_front;
            r_back   <= n_back;
            r_count  <= n_count;
            r_valid  <= n_valid;
            r_pop    <= n_pop;
            r_status <= n_status;
        end
    end

    assign o_result.valid  = r_valid;
    assign o_result.pop    = r_pop;
    assign o_result.status = r_status;
    assign o_result.count  = r_count;

endmodule

>>> rtl/double_ended_queue.sv
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit values held in a ring memory.
// A command is taken on a rising edge where i_start is high and o_busy is low.
// i_action selects push front, push back, pop front or pop back, and
// i_item_value carries the value for a push.
// Each command gives one result in the next cycle, marked by o_valid
// for a single cycle: the popped value (zero for pushes and failed pops),
// a status, the count after the command and an empty flag.
// While o_busy is low a new command may be issued in every cycle, so
// throughput is one command per clock; a result overlaps the next transfer.
// The single memory port serves either the write of a push or the read of a
// pop, and the read data register supplies the popped value directly.
// o_busy is high only while reset is applied and until r_busy clears after it.
// Reset empties the queue and clears both pointers; memory contents are left.
// The receiver cannot stall: a result must be taken in its strobe cycle.
module double_ended_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_action,
    input  logic signed [31:0] i_item_value,
    output logic        o_valid,
    output logic signed [31:0] o_popped_value,
    output logic [1:0]  o_status,
    output logic [4:0]  o_item_count,
    output logic        o_is_empty
);

    logic                      r_busy;
    logic                      accept;
    dq_pkg::t_mem_req          mem_req;
    dq_pkg::t_result           result;
    logic [dq_pkg::DATA_W-1:0] rdata;
    logic [dq_pkg::COUNT_W+dq_pkg::OUT_COUNT_W-1:0] count_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign o_busy = !i_rst_n || r_busy;
    assign accept = i_start && !o_busy;

    dq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_action  (i_action),
        .o_mem_req (mem_req),
        .o_result  (result)
    );

    dq_ram #(
        .WIDTH  (dq_pkg::DATA_W),
        .DEPTH  (dq_pkg::QUEUE_DEPTH),
        .ADDR_W (dq_pkg::ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_wr_en (mem_req.wr_en),
        .i_rd_en (mem_req.rd_en),
        .i_addr  (mem_req.addr),
        .i_wdata (i_item_value),
        .o_rdata (rdata)
    );

    assign count_ext      = {{dq_pkg::OUT_COUNT_W{1'b0}}, result.count};
    assign o_valid        = result.valid;
    assign o_popped_value = result.pop ? rdata : '0;
    assign o_status       = result.status;
    assign o_item_count   = count_ext[dq_pkg::OUT_COUNT_W-1:0];
    assign o_is_empty     = (result.count == '0);

endmodule

>>> rtl/dq_checker.sv
`timescale 1ns / 1ps

module dq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic [1:0]  i_action,
    input logic        o_valid,
    input logic [31:0] o_popped_value,
    input logic [1:0]  o_status,
    input logic        o_is_empty
);

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_valid)
        else $error("Accepted command gave no result.");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_start && !o_busy) |=> !o_valid)
        else $error("Result without an accepted command.");

    a_failed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != dq_pkg::ST_OK |-> o_popped_value == '0)
        else $error("Failed command returned a nonzero value.");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == dq_pkg::ST_EMPTY |-> o_is_empty)
        else $error("Empty status while the queue holds values.");

    a_push_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && !i_action[1] |=> !o_is_empty)
        else $error("Push left the queue empty.");

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);
